>>> hdl/gdc_pkg.sv
package gdc_pkg;

  // Field widths
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 16;
  localparam int ORD_W   = 9;

  // Gregorian reform year: valid years lie strictly above it
  localparam logic [YEAR_W-1:0] REFORM_YEAR = 14'd1582;

  // floor(y / 25) = (y * LEAP_RECIP) >> LEAP_SHIFT, exact for any 14-bit y
  localparam int LEAP_SHIFT = 20;
  localparam logic [15:0] LEAP_RECIP = 16'd41944;
  localparam int QUOT_W = 10;
  localparam logic [4:0] LEAP_DIV = 5'd25;

  // Operation codes
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADV  = 2'd1,
    OP_CMP  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Compare result codes
  typedef enum logic [1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } order_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MONTH = 2'd0,
    CFG_DAY   = 2'd1,
    CFG_YEAR  = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_idx_t;

  localparam int CFG_W = YEAR_W;

  typedef struct packed {
    logic [1:0]         operation;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [YEAR_W-1:0]  in_year;
    logic [COUNT_W-1:0] day_count;
  } cmd_t;

  typedef struct packed {
    logic               set_ok;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [YEAR_W-1:0]  cur_year;
    logic [1:0]         order;
    logic [ORD_W-1:0]   day_of_year;
  } rsp_t;

  // Month length; months outside 1..12 are zero days long
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in all valid months below m; months above 12 cover the whole year
  function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [ORD_W-1:0] base;
    unique case (m)
      4'd0, 4'd1: base = 9'd0;
      4'd2:       base = 9'd31;
      4'd3:       base = 9'd59;
      4'd4:       base = 9'd90;
      4'd5:       base = 9'd120;
      4'd6:       base = 9'd151;
      4'd7:       base = 9'd181;
      4'd8:       base = 9'd212;
      4'd9:       base = 9'd243;
      4'd10:      base = 9'd273;
      4'd11:      base = 9'd304;
      4'd12:      base = 9'd334;
      default:    base = 9'd365;
    endcase
    return base + ((leap && m >= 4'd3) ? 9'd1 : 9'd0);
  endfunction

endpackage

>>> hdl/gregorian_date_counter_top.sv
// Channel   | Signals                          | Handshake
// ----------+----------------------------------+-------------------------------
// command   | cmd (cmd_t)                      | start high while busy low
// result    | rsp (rsp_t)                      | done strobe, one cycle, no stall
// config    | cfg_we, cfg_index, cfg_data      | write when cfg_we high
//
// Set runs the leap test before its check; all operations end in ST_FIN and ST_OUT.
// Advance walks one month per ST_ADV_STEP and re-runs the leap test per year crossed.
// busy stays high until the result beat, which shows in the cycle busy drops;
// the next command may be accepted at the edge that ends that beat.
// Reset (rst, synchronous) loads 1/1/2000 into the defaults and the stored date.
// The receiver cannot stall results.
module gregorian_date_counter_top #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  gdc_pkg::cmd_t               cmd,
  output logic                        done,
  output gdc_pkg::rsp_t               rsp,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [gdc_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [gdc_pkg::YEAR_W-1:0] MAX_Y = gdc_pkg::YEAR_W'(MAX_YEAR);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP_MUL,
    ST_LEAP_RES,
    ST_SET_CHK,
    ST_ADV_STEP,
    ST_CMP,
    ST_FIN,
    ST_OUT
  } state_t;

  state_t state, ret_state;

  // Defaults and stored date
  logic [gdc_pkg::MONTH_W-1:0] def_month, month_reg;
  logic [gdc_pkg::DAY_W-1:0]   def_day, day_reg;
  logic [gdc_pkg::YEAR_W-1:0]  def_year, year_reg;

  // Latched command and work registers
  gdc_pkg::cmd_t               cmd_q;
  logic [gdc_pkg::COUNT_W-1:0] rem;
  logic [gdc_pkg::YEAR_W-1:0]  leap_yr;
  logic [gdc_pkg::QUOT_W-1:0]  quot;
  logic                        leap;
  logic                        ok_q;
  logic [1:0]                  ord_q;

  assign busy = (state != ST_IDLE);

  // Leap unit: multiply stage and residue stage
  logic [gdc_pkg::YEAR_W+15:0] quot_prod;
  logic [gdc_pkg::YEAR_W:0]    quot_x25;
  logic [gdc_pkg::YEAR_W:0]    resid;
  logic                        leap_next;

  assign quot_prod = {16'd0, leap_yr} * {{gdc_pkg::YEAR_W{1'b0}}, gdc_pkg::LEAP_RECIP};
  assign quot_x25  = (gdc_pkg::YEAR_W+1)'(quot) *
                     (gdc_pkg::YEAR_W+1)'(gdc_pkg::LEAP_DIV);
  assign resid     = {1'b0, leap_yr} - quot_x25;
  assign leap_next = (leap_yr[1:0] == 2'd0) &&
                     ((resid != '0) || (leap_yr[3:0] == 4'd0));

  // Set validation
  logic [gdc_pkg::DAY_W-1:0] in_len;
  logic                      set_valid;

  assign in_len    = gdc_pkg::month_days(cmd_q.in_month, leap);
  assign set_valid = (cmd_q.in_month >= 4'd1) && (cmd_q.in_month <= 4'd12) &&
                     (cmd_q.in_day >= 5'd1) && (cmd_q.in_day <= in_len) &&
                     (cmd_q.in_year > gdc_pkg::REFORM_YEAR) &&
                     (cmd_q.in_year <= MAX_Y);

  // Month step of the advance walk
  logic [gdc_pkg::DAY_W-1:0]   cur_len;
  logic                        has_room;
  logic [gdc_pkg::DAY_W-1:0]   room;
  logic                        fits;
  logic [gdc_pkg::COUNT_W-1:0] rem_next;
  logic [gdc_pkg::MONTH_W:0]   month_inc;

  assign cur_len   = gdc_pkg::month_days(month_reg, leap);
  assign has_room  = (day_reg < cur_len);
  assign room      = has_room ? (cur_len - day_reg) : '0;
  assign fits      = has_room && (rem <= gdc_pkg::COUNT_W'(room));
  assign rem_next  = rem - gdc_pkg::COUNT_W'(room) - 16'd1;
  assign month_inc = {1'b0, month_reg} + 5'd1;

  // Compare keys
  logic [gdc_pkg::YEAR_W+8:0] key_cur, key_in;

  assign key_cur = {year_reg, month_reg, day_reg};
  assign key_in  = {cmd_q.in_year, cmd_q.in_month, cmd_q.in_day};

  // Ordinal of the stored date
  logic [gdc_pkg::ORD_W-1:0] ordinal;

  assign ordinal = gdc_pkg::days_before(month_reg, leap) +
                   gdc_pkg::ORD_W'(day_reg);

  // Sequencer, date registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      def_month <= 4'd1;
      def_day   <= 5'd1;
      def_year  <= 14'd2000;
      month_reg <= 4'd1;
      day_reg   <= 5'd1;
      year_reg  <= 14'd2000;
      done      <= 1'b0;
      ok_q      <= 1'b0;
      ord_q     <= gdc_pkg::ORD_EARLIER;
    end else begin
      done <= 1'b0;

      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          gdc_pkg::CFG_MONTH: def_month <= cfg_data[gdc_pkg::MONTH_W-1:0];
          gdc_pkg::CFG_DAY:   def_day   <= cfg_data[gdc_pkg::DAY_W-1:0];
          gdc_pkg::CFG_YEAR:  def_year  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            rem   <= cmd.day_count;
            ok_q  <= 1'b0;
            ord_q <= gdc_pkg::ORD_EARLIER;
            unique case (cmd.operation)
              gdc_pkg::OP_SET: begin
                leap_yr   <= cmd.in_year;
                ret_state <= ST_SET_CHK;
                state     <= ST_LEAP_MUL;
              end
              gdc_pkg::OP_ADV: begin
                priority if (cmd.day_count == '0) begin
                  state <= ST_FIN;
                end else if (year_reg > MAX_Y) begin
                  month_reg <= 4'd12;
                  day_reg   <= 5'd31;
                  year_reg  <= MAX_Y;
                  state     <= ST_FIN;
                end else begin
                  leap_yr   <= year_reg;
                  ret_state <= ST_ADV_STEP;
                  state     <= ST_LEAP_MUL;
                end
              end
              gdc_pkg::OP_CMP: state <= ST_CMP;
              default:         state <= ST_FIN;
            endcase
          end
        end

        ST_LEAP_MUL: begin
          quot  <= quot_prod[gdc_pkg::LEAP_SHIFT +: gdc_pkg::QUOT_W];
          state <= ST_LEAP_RES;
        end

        ST_LEAP_RES: begin
          leap  <= leap_next;
          state <= ret_state;
        end

        ST_SET_CHK: begin
          ok_q <= set_valid;
          if (set_valid) begin
            month_reg <= cmd_q.in_month;
            day_reg   <= cmd_q.in_day;
            year_reg  <= cmd_q.in_year;
          end else begin
            month_reg <= def_month;
            day_reg   <= def_day;
            year_reg  <= def_year;
          end
          state <= ST_FIN;
        end

        // One month per cycle; a year crossing pauses the walk to re-run the leap unit
        ST_ADV_STEP: begin
          priority if (rem == '0) begin
            state <= ST_FIN;
          end else if (fits) begin
            day_reg <= day_reg + rem[gdc_pkg::DAY_W-1:0];
            rem     <= '0;
            state   <= ST_FIN;
          end else begin
            rem     <= rem_next;
            day_reg <= 5'd1;
            if (month_inc > 5'd12) begin
              if (year_reg >= MAX_Y) begin
                month_reg <= 4'd12;
                day_reg   <= 5'd31;
                year_reg  <= MAX_Y;
                state     <= ST_FIN;
              end else begin
                month_reg <= 4'd1;
                year_reg  <= year_reg + 14'd1;
                leap_yr   <= year_reg + 14'd1;
                ret_state <= ST_ADV_STEP;
                state     <= ST_LEAP_MUL;
              end
            end else begin
              month_reg <= month_inc[gdc_pkg::MONTH_W-1:0];
            end
          end
        end

        ST_CMP: begin
          priority if (key_cur < key_in) ord_q <= gdc_pkg::ORD_EARLIER;
          else if (key_cur == key_in)    ord_q <= gdc_pkg::ORD_EQUAL;
          else                           ord_q <= gdc_pkg::ORD_LATER;
          state <= ST_FIN;
        end

        // Leap test of the stored year for the ordinal
        ST_FIN: begin
          leap_yr   <= year_reg;
          ret_state <= ST_OUT;
          state     <= ST_LEAP_MUL;
        end

        ST_OUT: begin
          rsp.set_ok      <= ok_q;
          rsp.cur_month   <= month_reg;
          rsp.cur_day     <= day_reg;
          rsp.cur_year    <= year_reg;
          rsp.order       <= ord_q;
          rsp.day_of_year <= ordinal;
          done            <= 1'b1;
          state           <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_ok_valid: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.set_ok) |-> (cmd_q.operation == gdc_pkg::OP_SET &&
                              rsp.cur_month >= 4'd1 && rsp.cur_month <= 4'd12 &&
                              rsp.cur_day >= 5'd1))
    else $error("set reported valid with a bad stored date");

endmodule
